// File: hdl/g1sre_pkg.sv
// Package with shared types, constants and unit tables of the step range encoder.
`timescale 1ns / 1ps

package g1sre_pkg;

    // Default width of the start and end step fields.
    localparam int STEP_BITS = 24;
    // Width of a unit length in seconds (largest is 2592000).
    localparam int MULT_W = 22;
    // Remainder width: holds 65535 times the longest unit.
    localparam int REM_W = 38;
    localparam int QUOT_W = 16;
    localparam int LIST_LEN = 10;
    localparam int LONG_LIMIT_SEC = 918000;
    localparam logic [7:0] CUR_ALIAS = 8'd254;
    localparam logic [7:0] CUR_ALIAS_TO = 8'd15;
    localparam logic [3:0] HOUR_UNIT = 4'd1;

    // Status codes.
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_UNDEF = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       search_start;
        logic       search_wide;
        logic       search_use_end;
        logic       next_cand;
        logic       div_init;
        logic       div_step;
        logic       set_kind;
        logic [1:0] kind;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic zero;
        logic undef;
        logic force_wide;
        logic eq;
        logic gm;
        logic inst;
        logic wide;
        logic range_ok;
        logic div_last;
        logic fit;
        logic last_cand;
    } dp_stat_t;

    // Seconds per step unit code; zero marks an undefined code.
    function automatic logic [MULT_W-1:0] step_secs(input logic [3:0] code);
        logic [MULT_W-1:0] r;
        unique case (code)
            4'd0:    r = MULT_W'(60);
            4'd1:    r = MULT_W'(3600);
            4'd2:    r = MULT_W'(86400);
            4'd3:    r = MULT_W'(2592000);
            4'd10:   r = MULT_W'(10800);
            4'd11:   r = MULT_W'(21600);
            4'd12:   r = MULT_W'(43200);
            4'd13:   r = MULT_W'(1);
            4'd14:   r = MULT_W'(900);
            4'd15:   r = MULT_W'(1800);
            default: r = '0;
        endcase
        return r;
    endfunction

    // Seconds per header unit code.
    function automatic logic [MULT_W-1:0] hdr_secs(input logic [3:0] code);
        logic [MULT_W-1:0] r;
        unique case (code)
            4'd0:    r = MULT_W'(60);
            4'd1:    r = MULT_W'(3600);
            4'd2:    r = MULT_W'(86400);
            4'd3:    r = MULT_W'(2592000);
            4'd10:   r = MULT_W'(10800);
            4'd11:   r = MULT_W'(21600);
            4'd12:   r = MULT_W'(43200);
            4'd13:   r = MULT_W'(900);
            4'd14:   r = MULT_W'(1800);
            4'd15:   r = MULT_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    // Candidate unit list entry.
    function automatic logic [3:0] cand_unit(input logic [3:0] idx);
        logic [3:0] r;
        unique case (idx)
            4'd0:    r = 4'd1;
            4'd1:    r = 4'd0;
            4'd2:    r = 4'd10;
            4'd3:    r = 4'd11;
            4'd4:    r = 4'd12;
            4'd5:    r = 4'd2;
            4'd6:    r = 4'd0;
            4'd7:    r = 4'd13;
            4'd8:    r = 4'd14;
            4'd9:    r = 4'd15;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // First list position holding the current unit, or zero when absent.
    function automatic logic [3:0] cand_pos(input logic [7:0] cur);
        logic [3:0] r;
        unique case (cur)
            8'd1:    r = 4'd0;
            8'd0:    r = 4'd1;
            8'd10:   r = 4'd2;
            8'd11:   r = 4'd3;
            8'd12:   r = 4'd4;
            8'd2:    r = 4'd5;
            8'd13:   r = 4'd7;
            8'd14:   r = 4'd8;
            8'd15:   r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/grib1_step_range_encoder.sv
// Top level of the step range encoder: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
// Input items arrive on a valid/ready channel (in_valid, in_ready); one
// transaction carries start and end step, step unit, current header unit,
// the instant flag and the indicator-ten flag. Each item yields exactly one
// result transaction on out_valid/out_ready: status, P1, P2, unit code and
// the sixteen-bit-form flag. The compatibility mode register is written through
// cfg_wr_en/cfg_wr_data and should only change while the block is idle.
// Sequence: accept, multiply, decision, then the search. Items with both
// steps zero or an undefined step unit skip the search. A candidate unit
// whose range check fails is passed over; one that passes goes through
// check, the divider steps and evaluate. There are up to ten candidates
// per pass and at most two passes. One item is worked on at a time;
// the next item is accepted once the result sits in the output register,
// even if the receiver has not taken it yet. If the receiver stalls,
// the finished result holds and a second finished item waits in its
// final state. Reset clears the register to zero, empties the output
// register and returns the controller to idle.

module grib1_step_range_encoder #(
    parameter int STEP_BITS = g1sre_pkg::STEP_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [STEP_BITS-1:0] start_step,
    input  logic [STEP_BITS-1:0] end_step,
    input  logic [3:0]           step_unit_code,
    input  logic [7:0]           current_unit_code,
    input  logic                 is_instant,
    input  logic                 tri_is_ten,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [7:0]           p1_octet,
    output logic [7:0]           p2_octet,
    output logic [3:0]           unit_code,
    output logic                 tri_ten
);

    // Command and status bundles between the controller and the datapath.
    g1sre_pkg::dp_cmd_t  cmd;
    g1sre_pkg::dp_stat_t stat;

    g1sre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    g1sre_datapath #(
        .STEP_BITS (STEP_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .start_step        (start_step),
        .end_step          (end_step),
        .step_unit_code    (step_unit_code),
        .current_unit_code (current_unit_code),
        .is_instant        (is_instant),
        .tri_is_ten        (tri_is_ten),
        .status            (status),
        .p1_octet          (p1_octet),
        .p2_octet          (p2_octet),
        .unit_code         (unit_code),
        .tri_ten           (tri_ten)
    );

endmodule

// File: hdl/g1sre_datapath.sv
// Datapath: item registers, step multipliers, unit search and shift-subtract divider.
`timescale 1ns / 1ps

module g1sre_datapath #(
    parameter int STEP_BITS = g1sre_pkg::STEP_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  g1sre_pkg::dp_cmd_t       cmd,
    output g1sre_pkg::dp_stat_t      stat,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_wr_data,
    input  logic [STEP_BITS-1:0]     start_step,
    input  logic [STEP_BITS-1:0]     end_step,
    input  logic [3:0]               step_unit_code,
    input  logic [7:0]               current_unit_code,
    input  logic                     is_instant,
    input  logic                     tri_is_ten,
    output logic [1:0]               status,
    output logic [7:0]               p1_octet,
    output logic [7:0]               p2_octet,
    output logic [3:0]               unit_code,
    output logic                     tri_ten
);

    localparam int MULT_W = g1sre_pkg::MULT_W;
    localparam int REM_W = g1sre_pkg::REM_W;
    localparam int QUOT_W = g1sre_pkg::QUOT_W;
    localparam int SEC_W = STEP_BITS + MULT_W;
    localparam int CMP_W = (SEC_W > REM_W) ? SEC_W : REM_W;

    logic                 gm_reg;
    logic [STEP_BITS-1:0] start_reg;
    logic [STEP_BITS-1:0] end_reg;
    logic [3:0]           su_reg;
    logic [7:0]           cur_reg;
    logic                 inst_reg;
    logic                 tri_reg;
    logic [SEC_W-1:0]     s_sec_reg;
    logic [SEC_W-1:0]     e_sec_reg;
    logic [SEC_W-1:0]     a_sec_reg;
    logic                 wide_reg;
    logic [3:0]           k_reg;
    logic [REM_W-1:0]     rem_a_reg;
    logic [REM_W-1:0]     rem_b_reg;
    logic [REM_W-1:0]     div_reg;
    logic [QUOT_W-1:0]    q_a_reg;
    logic [QUOT_W-1:0]    q_b_reg;
    logic [3:0]           cnt_reg;
    logic [1:0]           kind_reg;

    logic [MULT_W-1:0]    mult;
    logic [MULT_W-1:0]    d;
    logic [REM_W-1:0]     lim_d;
    logic [4:0]           idx_sum;
    logic [3:0]           idx;
    logic [3:0]           unit;
    logic                 a_in_range;
    logic                 e_in_range;
    logic                 is_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gm_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            gm_reg <= cfg_wr_data;
        end
    end

    assign mult = g1sre_pkg::step_secs(su_reg);
    assign is_zero = (start_reg == '0) && (end_reg == '0);

    // Candidate zero is hours; the rest walk the list from the current unit.
    always_comb
    begin
        idx_sum = 5'({1'b0, g1sre_pkg::cand_pos(cur_reg)}) + 5'({1'b0, k_reg}) - 5'd1;
        if (idx_sum >= 5'(g1sre_pkg::LIST_LEN))
        begin
            idx = 4'(idx_sum - 5'(g1sre_pkg::LIST_LEN));
        end
        else
        begin
            idx = idx_sum[3:0];
        end
        unit = (k_reg == 4'd0) ? g1sre_pkg::HOUR_UNIT : g1sre_pkg::cand_unit(idx);
        d = g1sre_pkg::hdr_secs(unit);
        if (wide_reg)
        begin
            lim_d = REM_W'({d, 16'h0000}) - REM_W'(d);
        end
        else
        begin
            lim_d = REM_W'({d, 8'h00}) - REM_W'(d);
        end
        a_in_range = CMP_W'(a_sec_reg) <= CMP_W'(lim_d);
        e_in_range = CMP_W'(e_sec_reg) <= CMP_W'(lim_d);
    end

    always_comb
    begin
        stat.zero = is_zero;
        stat.undef = (mult == '0);
        stat.force_wide = tri_reg
            || (gm_reg && inst_reg
                && ((s_sec_reg > SEC_W'(g1sre_pkg::LONG_LIMIT_SEC))
                    || (e_sec_reg > SEC_W'(g1sre_pkg::LONG_LIMIT_SEC))));
        stat.eq = (start_reg == end_reg);
        stat.gm = gm_reg;
        stat.inst = inst_reg;
        stat.wide = wide_reg;
        stat.range_ok = a_in_range && (inst_reg || e_in_range);
        stat.div_last = (cnt_reg == 4'd0);
        stat.fit = (rem_a_reg == '0) && (inst_reg || (rem_b_reg == '0));
        stat.last_cand = (k_reg == 4'(g1sre_pkg::LIST_LEN - 1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            start_reg <= start_step;
            end_reg <= end_step;
            su_reg <= step_unit_code;
            cur_reg <= (current_unit_code == g1sre_pkg::CUR_ALIAS)
                       ? g1sre_pkg::CUR_ALIAS_TO : current_unit_code;
            inst_reg <= is_instant;
            tri_reg <= tri_is_ten;
        end
        if (cmd.mul)
        begin
            s_sec_reg <= SEC_W'(start_reg) * SEC_W'(mult);
            e_sec_reg <= SEC_W'(end_reg) * SEC_W'(mult);
        end
        if (cmd.search_start)
        begin
            wide_reg <= cmd.search_wide;
            a_sec_reg <= cmd.search_use_end ? e_sec_reg : s_sec_reg;
            k_reg <= 4'd0;
        end
        else if (cmd.next_cand)
        begin
            k_reg <= k_reg + 4'd1;
        end
        if (cmd.div_init)
        begin
            rem_a_reg <= REM_W'(a_sec_reg);
            rem_b_reg <= REM_W'(e_sec_reg);
            div_reg <= REM_W'(d) << (QUOT_W - 1);
            cnt_reg <= 4'(QUOT_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (rem_a_reg >= div_reg)
            begin
                rem_a_reg <= rem_a_reg - div_reg;
                q_a_reg <= {q_a_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                q_a_reg <= {q_a_reg[QUOT_W-2:0], 1'b0};
            end
            if (rem_b_reg >= div_reg)
            begin
                rem_b_reg <= rem_b_reg - div_reg;
                q_b_reg <= {q_b_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                q_b_reg <= {q_b_reg[QUOT_W-2:0], 1'b0};
            end
            div_reg <= div_reg >> 1;
            cnt_reg <= cnt_reg - 4'd1;
        end
        if (cmd.set_kind)
        begin
            kind_reg <= cmd.kind;
        end
        if (cmd.out_load)
        begin
            status <= kind_reg;
            if ((kind_reg == g1sre_pkg::ST_OK) && !is_zero)
            begin
                if (wide_reg)
                begin
                    p1_octet <= q_a_reg[15:8];
                    p2_octet <= q_a_reg[7:0];
                end
                else
                begin
                    p1_octet <= q_a_reg[7:0];
                    p2_octet <= inst_reg ? 8'h00 : q_b_reg[7:0];
                end
                unit_code <= unit;
                tri_ten <= wide_reg;
            end
            else
            begin
                p1_octet <= 8'h00;
                p2_octet <= 8'h00;
                unit_code <= cur_reg[3:0];
                tri_ten <= 1'b0;
            end
        end
    end

endmodule

// File: hdl/g1sre_ctrl.sv
// Controller state machine that sequences the unit search and the output handshake.
`timescale 1ns / 1ps

module g1sre_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  g1sre_pkg::dp_stat_t  stat,
    output g1sre_pkg::dp_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV = 3'd4;
    localparam logic [2:0] S_EVAL = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       fallback_ok;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign fallback_ok = !stat.wide && (stat.inst || stat.gm) && (stat.eq || stat.gm);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (stat.zero)
                begin
                    cmd.set_kind = 1'b1;
                    cmd.kind = g1sre_pkg::ST_OK;
                end
                else if (stat.undef)
                begin
                    cmd.set_kind = 1'b1;
                    cmd.kind = g1sre_pkg::ST_UNDEF;
                end
                else if (stat.force_wide && !(stat.eq || stat.gm))
                begin
                    cmd.set_kind = 1'b1;
                    cmd.kind = g1sre_pkg::ST_NOFIT;
                end
                else
                begin
                    cmd.search_start = 1'b1;
                    cmd.search_wide = stat.force_wide;
                    state_next = S_CHECK;
                end
            end
            S_CHECK, S_EVAL:
            begin
                if ((state_reg == S_CHECK) && stat.range_ok)
                begin
                    cmd.div_init = 1'b1;
                    state_next = S_DIV;
                end
                else if ((state_reg == S_EVAL) && stat.fit)
                begin
                    cmd.set_kind = 1'b1;
                    cmd.kind = g1sre_pkg::ST_OK;
                    state_next = S_DONE;
                end
                else if (!stat.last_cand)
                begin
                    cmd.next_cand = 1'b1;
                    state_next = S_CHECK;
                end
                else if (fallback_ok)
                begin
                    // The one-octet search failed: retry in sixteen-bit form on the end value.
                    cmd.search_start = 1'b1;
                    cmd.search_wide = 1'b1;
                    cmd.search_use_end = 1'b1;
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.set_kind = 1'b1;
                    cmd.kind = g1sre_pkg::ST_NOFIT;
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_EVAL;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while pending");

    // An accepted transaction always moves on to the multiply step.
    a_accept_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MUL))
        else $error("accept did not start the multiply");

    // Divider start is always followed by division steps.
    a_div_follow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_init |=> (state_reg == S_DIV))
        else $error("divider started without steps");

    // A search begins only from the decision or search states.
    a_search_src: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search_start |-> (state_reg == S_DECIDE || state_reg == S_CHECK
                              || state_reg == S_EVAL))
        else $error("search started from wrong state");

endmodule
